// ===== hdl/rne_pkg.sv =====
package rne_pkg;

  // Width of the expanded-length and byte counters; both saturate at all ones.
  localparam int LENGTH_WIDTH = 20;
  // Width of the total_length field on the end beat.
  localparam int TOTAL_WIDTH = 20;
  localparam int SYMBOL_WIDTH = 8;
  localparam int RUN_WIDTH = 7;
  localparam int BYTE_WIDTH = 8;

  // Result queue: one accepted byte may push up to three beats.
  localparam int MAX_BURST = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_WIDTH-1:0] CHAR_OPEN = 8'h28;
  localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_WIDTH-1:0] CHAR_NINE = 8'h39;

  typedef logic [LENGTH_WIDTH-1:0] length_t;

  typedef struct packed {
    logic [SYMBOL_WIDTH-1:0] symbol;
    logic [RUN_WIDTH-1:0]    run_length;
    logic [TOTAL_WIDTH-1:0]  total_length;
    logic                    syntax_error;
    logic                    end_item;
  } result_t;

  // Saturating add of a small increment to a length counter.
  function automatic length_t sat_add(input length_t a, input logic [RUN_WIDTH:0] inc);
    logic [LENGTH_WIDTH:0] s;
    s = {1'b0, a} + (LENGTH_WIDTH + 1)'(inc);
    return s[LENGTH_WIDTH] ? {LENGTH_WIDTH{1'b1}} : s[LENGTH_WIDTH-1:0];
  endfunction

  // Low bits of a counter as shown on the end beat (zero-extended if narrower).
  function automatic logic [TOTAL_WIDTH-1:0] to_total(input length_t a);
    logic [63:0] w;
    w = 64'(a);
    return w[TOTAL_WIDTH-1:0];
  endfunction

endpackage

// ===== hdl/rne_if.sv =====
interface rne_in_if;
  logic                             valid;
  logic                             ready;
  logic [rne_pkg::BYTE_WIDTH-1:0]   in_byte;
  logic                             is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

interface rne_out_if;
  logic                             valid;
  logic                             ready;
  logic [rne_pkg::SYMBOL_WIDTH-1:0] symbol;
  logic [rne_pkg::RUN_WIDTH-1:0]    run_length;
  logic [rne_pkg::TOTAL_WIDTH-1:0]  total_length;
  logic                             syntax_error;
  logic                             end_item;

  modport source (output valid, output symbol, output run_length, output total_length,
                  output syntax_error, output end_item, input ready);
  modport sink (input valid, input symbol, input run_length, input total_length,
                input syntax_error, input end_item, output ready);
endinterface

// ===== hdl/repeat_notation_expander.sv =====
// Repeat notation expander. Bytes of an allele string arrive one per beat on
// the inbound channel, the last one flagged by is_final. Each byte is parsed in
// the cycle it is accepted: a plain byte yields a run of length one, and a group
// written as '(' symbol, one ignored byte, and a one- or two-digit count from 1
// to 99 yields a single run of that symbol. The final byte adds an end beat with
// the expanded length (saturating) and a syntax-error flag; after an error the
// rest of the string is counted but produces no runs, and the end beat carries
// the input byte count instead, so the consumer should drop the runs and keep
// the original string. A byte pushes zero to three beats into a four-entry
// result queue that drains one beat per cycle while the consumer is ready; the
// inbound channel is ready whenever the queue can take three more beats, that
// is, when at most one beat is waiting. A stream that yields one beat per byte
// therefore runs at one byte per clock if unstalled; the sustained rate is set
// by the number of result beats per byte. After the end beat the parser is
// back in its reset state and the next string may follow in the next cycle.
module repeat_notation_expander (
  input  logic              clk,
  input  logic              rst,
  rne_in_if.sink            inbound,
  rne_out_if.source         outbound
);

  typedef enum logic [2:0] {
    MODE_LIT,
    MODE_OPEN,
    MODE_SKIP,
    MODE_DIG0,
    MODE_DIG1,
    MODE_DIG2,
    MODE_ERR
  } mode_t;

  // Parser state.
  mode_t                                mode;
  logic [rne_pkg::SYMBOL_WIDTH-1:0]     held_symbol;
  logic [rne_pkg::RUN_WIDTH-1:0]        digit_value;
  rne_pkg::length_t                     expanded_count;
  rne_pkg::length_t                     byte_count;

  // Result queue.
  rne_pkg::result_t                     queue [rne_pkg::QUEUE_DEPTH];
  logic [rne_pkg::QPTR_WIDTH-1:0]       wptr;
  logic [rne_pkg::QPTR_WIDTH-1:0]       rptr;
  logic [rne_pkg::QCNT_WIDTH-1:0]       count;

  logic                                 accept;
  logic                                 pop;

  // Next-state and per-byte results.
  mode_t                                mode_next;
  logic [rne_pkg::SYMBOL_WIDTH-1:0]     held_symbol_next;
  logic [rne_pkg::RUN_WIDTH-1:0]        digit_value_next;
  rne_pkg::length_t                     expanded_sum;
  rne_pkg::length_t                     byte_sum;
  logic                                 is_digit;
  logic [rne_pkg::RUN_WIDTH-1:0]        digit;
  logic                                 close_run;
  logic                                 lit_run;
  logic                                 err_final;
  logic [rne_pkg::RUN_WIDTH:0]          grow;
  rne_pkg::result_t                     close_item;
  rne_pkg::result_t                     lit_item;
  rne_pkg::result_t                     end_item;
  logic [rne_pkg::QPTR_WIDTH-1:0]       lit_slot;
  logic [rne_pkg::QPTR_WIDTH-1:0]       end_slot;
  logic [rne_pkg::QCNT_WIDTH-1:0]       push_count;

  assign accept = inbound.valid && inbound.ready;
  assign pop    = outbound.valid && outbound.ready;

  // Room for a full burst must exist before a byte is taken.
  assign inbound.ready = count <= rne_pkg::QCNT_WIDTH'(rne_pkg::QUEUE_DEPTH - rne_pkg::MAX_BURST);

  assign is_digit = (inbound.in_byte >= rne_pkg::CHAR_ZERO) &&
                    (inbound.in_byte <= rne_pkg::CHAR_NINE);
  assign digit = is_digit ? rne_pkg::RUN_WIDTH'(inbound.in_byte - rne_pkg::CHAR_ZERO)
                          : '0;

  // One pass of the parser over the accepted byte.
  always_comb begin
    mode_next        = mode;
    held_symbol_next = held_symbol;
    digit_value_next = digit_value;
    close_run        = 1'b0;
    lit_run          = 1'b0;
    case (mode)
      MODE_LIT: begin
        if (inbound.in_byte == rne_pkg::CHAR_OPEN) begin
          mode_next = MODE_OPEN;
        end else begin
          lit_run = 1'b1;
        end
      end
      MODE_OPEN: begin
        held_symbol_next = inbound.in_byte;
        mode_next        = MODE_SKIP;
      end
      MODE_SKIP: begin
        mode_next = MODE_DIG0;
      end
      MODE_DIG0: begin
        if (is_digit) begin
          digit_value_next = digit;
          mode_next        = MODE_DIG1;
        end else begin
          mode_next = MODE_ERR;
        end
      end
      MODE_DIG1, MODE_DIG2: begin
        if (is_digit) begin
          if (mode == MODE_DIG1) begin
            // The first digit is at most nine, so ten times it fits.
            digit_value_next = (digit_value << 3) + (digit_value << 1) + digit;
            mode_next        = MODE_DIG2;
          end else begin
            mode_next = MODE_ERR;
          end
        end else if (digit_value == '0) begin
          mode_next = MODE_ERR;
        end else begin
          // The count ends here and the byte is read again as a literal.
          close_run = 1'b1;
          if (inbound.in_byte == rne_pkg::CHAR_OPEN) begin
            mode_next = MODE_OPEN;
          end else begin
            lit_run   = 1'b1;
            mode_next = MODE_LIT;
          end
        end
      end
      default: begin
        mode_next = MODE_ERR;
      end
    endcase

    // The end of the string closes an open count or flags a truncated group.
    if (inbound.is_final) begin
      case (mode_next)
        MODE_OPEN, MODE_SKIP, MODE_DIG0: begin
          mode_next = MODE_ERR;
        end
        MODE_DIG1, MODE_DIG2: begin
          if (digit_value_next == '0) begin
            mode_next = MODE_ERR;
          end else begin
            close_run = 1'b1;
            mode_next = MODE_LIT;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign err_final = (mode_next == MODE_ERR);

  // A closing run and a literal may both add to the length in one byte.
  assign grow = (close_run ? {1'b0, digit_value_next} : '0) +
                (rne_pkg::RUN_WIDTH + 1)'(lit_run);
  assign expanded_sum = rne_pkg::sat_add(expanded_count, grow);
  assign byte_sum     = rne_pkg::sat_add(byte_count, (rne_pkg::RUN_WIDTH + 1)'(1));

  always_comb begin
    close_item              = '0;
    close_item.symbol       = held_symbol_next;
    close_item.run_length   = digit_value_next;
    lit_item                = '0;
    lit_item.symbol         = inbound.in_byte;
    lit_item.run_length     = rne_pkg::RUN_WIDTH'(1);
    end_item                = '0;
    end_item.total_length   = rne_pkg::to_total(err_final ? byte_sum : expanded_sum);
    end_item.syntax_error   = err_final;
    end_item.end_item       = 1'b1;
  end

  // Beats of one byte go into consecutive slots: closing run, literal, end.
  assign lit_slot   = wptr + rne_pkg::QPTR_WIDTH'(close_run);
  assign end_slot   = lit_slot + rne_pkg::QPTR_WIDTH'(lit_run);
  assign push_count = rne_pkg::QCNT_WIDTH'(close_run) + rne_pkg::QCNT_WIDTH'(lit_run) +
                      rne_pkg::QCNT_WIDTH'(inbound.is_final);

  always_ff @(posedge clk) begin
    if (accept) begin
      if (close_run) begin
        queue[wptr] <= close_item;
      end
      if (lit_run) begin
        queue[lit_slot] <= lit_item;
      end
      if (inbound.is_final) begin
        queue[end_slot] <= end_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_LIT;
      held_symbol    <= '0;
      digit_value    <= '0;
      expanded_count <= '0;
      byte_count     <= '0;
      wptr           <= '0;
      rptr           <= '0;
      count          <= '0;
    end else begin
      if (accept) begin
        if (inbound.is_final) begin
          mode           <= MODE_LIT;
          held_symbol    <= '0;
          digit_value    <= '0;
          expanded_count <= '0;
          byte_count     <= '0;
        end else begin
          mode           <= mode_next;
          held_symbol    <= held_symbol_next;
          digit_value    <= digit_value_next;
          expanded_count <= expanded_sum;
          byte_count     <= byte_sum;
        end
        wptr <= wptr + rne_pkg::QPTR_WIDTH'(push_count);
      end
      if (pop) begin
        rptr <= rptr + rne_pkg::QPTR_WIDTH'(1);
      end
      count <= count + (accept ? push_count : '0) - rne_pkg::QCNT_WIDTH'(pop);
    end
  end

  assign outbound.valid        = count != '0;
  assign outbound.symbol       = queue[rptr].symbol;
  assign outbound.run_length   = queue[rptr].run_length;
  assign outbound.total_length = queue[rptr].total_length;
  assign outbound.syntax_error = queue[rptr].syntax_error;
  assign outbound.end_item     = queue[rptr].end_item;

`ifndef SYNTH
  // The queue never holds more beats than it has entries.
  assert property (@(posedge clk) disable iff (rst)
    count <= rne_pkg::QCNT_WIDTH'(rne_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // A run beat always repeats its symbol at least once.
  assert property (@(posedge clk) disable iff (rst)
    outbound.valid && !outbound.end_item |-> outbound.run_length != '0)
    else $error("run beat with zero length");

  // The end beat carries no symbol and no run.
  assert property (@(posedge clk) disable iff (rst)
    outbound.valid && outbound.end_item |->
      outbound.symbol == '0 && outbound.run_length == '0)
    else $error("end beat carries a run");

  // After the final byte the parser is back in its reset state.
  assert property (@(posedge clk) disable iff (rst)
    accept && inbound.is_final |=>
      mode == MODE_LIT && expanded_count == '0 && byte_count == '0)
    else $error("parser not cleared after final byte");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rne_pkg::*;

  // The parser state kept by the expansion predictor below. The encoding is
  // local to the testbench; only the order of the parse steps matters.
  typedef enum logic [2:0] {
    PM_LITERAL,
    PM_OPEN,
    PM_SKIP,
    PM_FIRST_DIGIT,
    PM_SECOND_DIGIT,
    PM_AFTER_COUNT,
    PM_ERROR
  } parse_mode_t;

  // One row of the directed table. When typed is set, the row is the final
  // byte of a string whose end beat can be read off by eye. Its total and
  // error flag then replace the predicted ones.
  typedef struct packed {
    logic [BYTE_WIDTH-1:0]  code;
    logic                   last;
    logic                   typed;
    logic [TOTAL_WIDTH-1:0] total;
    logic                   err;
  } stim_row_t;

  localparam longint unsigned COUNT_CEILING = (64'd1 << LENGTH_WIDTH) - 64'd1;
  localparam int NUM_PHASES = 4;
  localparam int PHASE_BYTES = 75;
  // Idle and stall percentages per phase: none, sender, receiver, both.
  localparam int SEND_IDLE [NUM_PHASES] = '{0, 72, 0, 17};
  localparam int RECV_STALL [NUM_PHASES] = '{0, 0, 72, 17};
  localparam int DRAIN_LIMIT = 10000;
  localparam int TAIL_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;

  localparam int NUM_DIRECTED = 29;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    // Two literal bytes at the two ends of the byte range.
    '{8'h00, 1'b0, 1'b0, 20'd0, 1'b0},
    '{8'hFF, 1'b1, 1'b1, 20'd2, 1'b0},
    // A count with a leading zero: "(X-05" expands to five.
    '{CHAR_OPEN, 1'b0, 1'b0, 20'd0, 1'b0},
    '{"X", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"-", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"0", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"5", 1'b1, 1'b1, 20'd5, 1'b0},
    // The largest count, closed by a non-digit that is then a literal.
    '{CHAR_OPEN, 1'b0, 1'b0, 20'd0, 1'b0},
    '{"Y", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"?", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"9", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"9", 1'b0, 1'b0, 20'd0, 1'b0},
    '{")", 1'b1, 1'b1, 20'd100, 1'b0},
    // A string that ends right after the opening parenthesis.
    '{CHAR_OPEN, 1'b1, 1'b1, 20'd1, 1'b1},
    // No digit where the count starts; the trailing byte is swallowed.
    '{CHAR_OPEN, 1'b0, 1'b0, 20'd0, 1'b0},
    '{"Z", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"z", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"a", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"b", 1'b1, 1'b1, 20'd5, 1'b1},
    // Three count digits.
    '{CHAR_OPEN, 1'b0, 1'b0, 20'd0, 1'b0},
    '{"Q", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"+", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"1", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"2", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"3", 1'b1, 1'b1, 20'd6, 1'b1},
    // A zero count, closed by the end of the string.
    '{CHAR_OPEN, 1'b0, 1'b0, 20'd0, 1'b0},
    '{"W", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"=", 1'b0, 1'b0, 20'd0, 1'b0},
    '{"0", 1'b1, 1'b1, 20'd4, 1'b1}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  rne_in_if  inb ();
  rne_out_if outb ();

  repeat_notation_expander u_dut (
    .clk      (clk),
    .rst      (rst),
    .inbound  (inb),
    .outbound (outb)
  );

  always #5 clk = ~clk;

  // Predictor state, a private copy of what the parser should hold.
  parse_mode_t            mode_q;
  logic [SYMBOL_WIDTH-1:0] held_symbol_q;
  logic [RUN_WIDTH-1:0]    count_q;
  length_t                 expanded_q;
  length_t                 bytes_q;

  // Beats the block still owes, oldest first.
  result_t pending_runs [$];
  // Bytes of the random string being sent.
  logic [BYTE_WIDTH-1:0] string_bytes [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;

  result_t seen_beat;
  result_t want_beat;

  function automatic void note_failure(input string msg);
    if (fail_count < REPORT_LIMIT) begin
      $display("mismatch: %s", msg);
    end
    fail_count++;
  endfunction

  function automatic bit is_digit(input logic [BYTE_WIDTH-1:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  // Add to a length counter, holding at the all-ones ceiling.
  function automatic length_t bump_length(input length_t a, input int unsigned inc);
    longint unsigned s;
    s = longint'(a) + longint'(inc);
    return (s > COUNT_CEILING) ? length_t'(COUNT_CEILING) : length_t'(s);
  endfunction

  function automatic void push_run(input logic [SYMBOL_WIDTH-1:0] sym,
                                   input logic [RUN_WIDTH-1:0] len);
    result_t r;
    r = '0;
    r.symbol = sym;
    r.run_length = len;
    pending_runs.push_back(r);
  endfunction

  function automatic void reset_parser();
    mode_q = PM_LITERAL;
    held_symbol_q = '0;
    count_q = '0;
    expanded_q = '0;
    bytes_q = '0;
  endfunction

  // A byte read outside a group: either it opens one or it is a run of one.
  function automatic void take_literal(input logic [BYTE_WIDTH-1:0] b);
    if (b == CHAR_OPEN) begin
      mode_q = PM_OPEN;
    end else begin
      expanded_q = bump_length(expanded_q, 1);
      push_run(b, RUN_WIDTH'(1));
    end
  endfunction

  // Finish a group whose count has been read. A zero count is malformed.
  function automatic void close_count();
    if (count_q == '0) begin
      mode_q = PM_ERROR;
    end else begin
      expanded_q = bump_length(expanded_q, count_q);
      mode_q = PM_LITERAL;
      push_run(held_symbol_q, count_q);
    end
  endfunction

  // Advance the parser by one accepted byte and queue the beats it causes.
  function automatic void expand_byte(input logic [BYTE_WIDTH-1:0] b, input logic last);
    logic [BYTE_WIDTH-1:0] digit;
    result_t               end_beat;
    digit = b - CHAR_ZERO;
    bytes_q = bump_length(bytes_q, 1);
    case (mode_q)
      PM_LITERAL: begin
        take_literal(b);
      end
      PM_OPEN: begin
        held_symbol_q = b;
        mode_q = PM_SKIP;
      end
      PM_SKIP: begin
        mode_q = PM_FIRST_DIGIT;
      end
      PM_FIRST_DIGIT: begin
        if (is_digit(b)) begin
          count_q = RUN_WIDTH'(digit);
          mode_q = PM_SECOND_DIGIT;
        end else begin
          mode_q = PM_ERROR;
        end
      end
      PM_SECOND_DIGIT: begin
        if (is_digit(b)) begin
          count_q = RUN_WIDTH'(int'(count_q) * 10 + int'(digit));
          mode_q = PM_AFTER_COUNT;
        end else begin
          close_count();
          if (mode_q == PM_LITERAL) take_literal(b);
        end
      end
      PM_AFTER_COUNT: begin
        if (is_digit(b)) begin
          mode_q = PM_ERROR;
        end else begin
          close_count();
          if (mode_q == PM_LITERAL) take_literal(b);
        end
      end
      default: begin
        mode_q = PM_ERROR;
      end
    endcase
    if (last) begin
      if (mode_q == PM_OPEN || mode_q == PM_SKIP || mode_q == PM_FIRST_DIGIT) begin
        mode_q = PM_ERROR;
      end else if (mode_q == PM_SECOND_DIGIT || mode_q == PM_AFTER_COUNT) begin
        close_count();
      end
      end_beat = '0;
      end_beat.end_item = 1'b1;
      end_beat.syntax_error = (mode_q == PM_ERROR);
      end_beat.total_length = (mode_q == PM_ERROR) ? TOTAL_WIDTH'(bytes_q)
                                                   : TOTAL_WIDTH'(expanded_q);
      pending_runs.push_back(end_beat);
      reset_parser();
    end
  endfunction

  // Offer one byte and hold it until the block takes it. Valid is only
  // lowered while idling, so a back-to-back byte never lowers and raises it
  // in the same time step. The caller lowers valid before any other wait.
  task automatic send_byte(input logic [BYTE_WIDTH-1:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      inb.valid <= 1'b0;
      @(posedge clk);
    end
    inb.valid    <= 1'b1;
    inb.in_byte  <= b;
    inb.is_final <= last;
    do @(posedge clk); while (!inb.ready);
    expand_byte(b, last);
  endtask

  // Stop sending and wait until every owed beat has come out.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    inb.valid <= 1'b0;
    while (pending_runs.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // Build one random string. Most strings are a few well-formed tokens with
  // random content; some carry a broken group, and a tenth are pure noise
  // drawn from parentheses, digits and arbitrary bytes.
  task automatic compose_string();
    int unsigned           tokens;
    int unsigned           pick;
    int unsigned           count;
    logic [BYTE_WIDTH-1:0] b;
    bit                    after_group;
    string_bytes.delete();
    after_group = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 2))
          0: string_bytes.push_back(CHAR_OPEN);
          1: string_bytes.push_back(CHAR_ZERO + BYTE_WIDTH'($urandom_range(0, 9)));
          default: string_bytes.push_back(BYTE_WIDTH'($urandom_range(0, 255)));
        endcase
      end
      return;
    end
    tokens = $urandom_range(1, 6);
    for (int t = 0; t < tokens; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // A literal; a digit right after a count would be read as part of the count.
        do b = BYTE_WIDTH'($urandom_range(0, 255));
        while (b == CHAR_OPEN || (after_group && is_digit(b)));
        string_bytes.push_back(b);
        after_group = 1'b0;
      end else if (pick < 88) begin
        count = $urandom_range(1, 99);
        string_bytes.push_back(CHAR_OPEN);
        string_bytes.push_back(BYTE_WIDTH'($urandom_range(0, 255)));
        string_bytes.push_back(BYTE_WIDTH'($urandom_range(0, 255)));
        if (count >= 10 || $urandom_range(0, 1) == 1) begin
          string_bytes.push_back(CHAR_ZERO + BYTE_WIDTH'(count / 10));
        end
        string_bytes.push_back(CHAR_ZERO + BYTE_WIDTH'(count % 10));
        after_group = 1'b1;
      end else begin
        string_bytes.push_back(CHAR_OPEN);
        case ($urandom_range(0, 3))
          0: begin
            // The string stops inside the group.
            repeat ($urandom_range(0, 2)) begin
              string_bytes.push_back(BYTE_WIDTH'($urandom_range(0, 255)));
            end
            return;
          end
          1: begin
            string_bytes.push_back(BYTE_WIDTH'($urandom_range(0, 255)));
            string_bytes.push_back(BYTE_WIDTH'($urandom_range(0, 255)));
            string_bytes.push_back(CHAR_ZERO);
            if ($urandom_range(0, 1) == 1) string_bytes.push_back(CHAR_ZERO);
          end
          2: begin
            string_bytes.push_back(BYTE_WIDTH'($urandom_range(0, 255)));
            string_bytes.push_back(BYTE_WIDTH'($urandom_range(0, 255)));
            repeat (3) begin
              string_bytes.push_back(CHAR_ZERO + BYTE_WIDTH'($urandom_range(0, 9)));
            end
          end
          default: begin
            string_bytes.push_back(BYTE_WIDTH'($urandom_range(0, 255)));
            string_bytes.push_back(BYTE_WIDTH'($urandom_range(0, 255)));
            do b = BYTE_WIDTH'($urandom_range(0, 255));
            while (is_digit(b));
            string_bytes.push_back(b);
          end
        endcase
        after_group = 1'b1;
      end
    end
  endtask

  // Receiver side: ready is redrawn at every edge from the phase's stall rate.
  always @(posedge clk) begin
    outb.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Every beat the block hands over is compared, field by field, with the
  // oldest beat still owed.
  always @(posedge clk) begin
    if (!rst && outb.valid && outb.ready) begin
      seen_beat.symbol       = outb.symbol;
      seen_beat.run_length   = outb.run_length;
      seen_beat.total_length = outb.total_length;
      seen_beat.syntax_error = outb.syntax_error;
      seen_beat.end_item     = outb.end_item;
      if (pending_runs.size() == 0) begin
        note_failure($sformatf("beat with nothing owed: sym=%h run=%0d tot=%0d err=%b end=%b",
                               seen_beat.symbol, seen_beat.run_length,
                               seen_beat.total_length, seen_beat.syntax_error,
                               seen_beat.end_item));
      end else begin
        want_beat = pending_runs.pop_front();
        if (seen_beat.symbol !== want_beat.symbol ||
            seen_beat.run_length !== want_beat.run_length ||
            seen_beat.total_length !== want_beat.total_length ||
            seen_beat.syntax_error !== want_beat.syntax_error ||
            seen_beat.end_item !== want_beat.end_item) begin
          note_failure($sformatf(
            "expected sym=%h run=%0d tot=%0d err=%b end=%b, got sym=%h run=%0d tot=%0d err=%b end=%b",
            want_beat.symbol, want_beat.run_length, want_beat.total_length,
            want_beat.syntax_error, want_beat.end_item,
            seen_beat.symbol, seen_beat.run_length, seen_beat.total_length,
            seen_beat.syntax_error, seen_beat.end_item));
        end
      end
    end
  end

  initial begin
    int unsigned phase_bytes;
    inb.valid = 1'b0;
    inb.in_byte = '0;
    inb.is_final = 1'b0;
    reset_parser();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed strings first, with no idling on either side. Typed rows pin
    // the end beat to the value written in the table.
    foreach (DIRECTED[i]) begin
      send_byte(DIRECTED[i].code, DIRECTED[i].last);
      if (DIRECTED[i].typed) begin
        pending_runs[pending_runs.size() - 1].total_length = DIRECTED[i].total;
        pending_runs[pending_runs.size() - 1].syntax_error = DIRECTED[i].err;
      end
    end

    // Random strings, one phase per idling pattern. Between phases the sender
    // holds off until every owed beat has drained.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      send_idle_pct = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        compose_string();
        foreach (string_bytes[j]) begin
          send_byte(string_bytes[j], j == string_bytes.size() - 1);
          phase_bytes++;
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_runs.size() != 0) begin
      note_failure($sformatf("%0d beats never arrived", pending_runs.size()));
    end
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Watchdog: the slowest correct run is well under a tenth of this.
  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rne_pkg.sv
hdl/rne_if.sv
hdl/repeat_notation_expander.sv
tb/tb.sv
